[hw/rtl/pul_pkg.sv]
// ----------------------------------------------------------------------------
// pul_pkg
// Types, constants, the factorial table and the control store of the
// permutation unranking block.
// ----------------------------------------------------------------------------
package pul_pkg;

  localparam int MAX_SIZE = 12;
  localparam int RANK_W   = 29;
  localparam int SIZE_W   = 4;
  localparam int POS_W    = 4;
  localparam int ELEM_W   = 4;

  typedef logic [RANK_W-1:0] rank_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [MAX_SIZE:0] vmask_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SUB,
    S_EMIT,
    S_ERR
  } step_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_SUB,
    ACT_EMIT,
    ACT_ERR
  } act_t;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_GE,
    C_LAST
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    logic  wait_slot;
    step_t on_true;
    step_t on_false;
  } ctrl_word_t;

  function automatic rank_t fact(input size_t idx);
    rank_t f;
    case (idx)
      4'd0:    f = 29'd1;
      4'd1:    f = 29'd1;
      4'd2:    f = 29'd2;
      4'd3:    f = 29'd6;
      4'd4:    f = 29'd24;
      4'd5:    f = 29'd120;
      4'd6:    f = 29'd720;
      4'd7:    f = 29'd5040;
      4'd8:    f = 29'd40320;
      4'd9:    f = 29'd362880;
      4'd10:   f = 29'd3628800;
      4'd11:   f = 29'd39916800;
      4'd12:   f = 29'd479001600;
      default: f = 29'd479001600;
    endcase
    return f;
  endfunction

  // Control store: one word per step.
  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t w;
    case (s)
      S_IDLE:  w = '{act: ACT_LOAD, cond: C_ACCEPT, wait_slot: 1'b0,
                     on_true: S_CHECK, on_false: S_IDLE};
      S_CHECK: w = '{act: ACT_NONE, cond: C_GE, wait_slot: 1'b0,
                     on_true: S_ERR, on_false: S_SUB};
      S_SUB:   w = '{act: ACT_SUB, cond: C_GE, wait_slot: 1'b0,
                     on_true: S_SUB, on_false: S_EMIT};
      S_EMIT:  w = '{act: ACT_EMIT, cond: C_LAST, wait_slot: 1'b1,
                     on_true: S_IDLE, on_false: S_SUB};
      S_ERR:   w = '{act: ACT_ERR, cond: C_ALWAYS, wait_slot: 1'b1,
                     on_true: S_IDLE, on_false: S_IDLE};
      default: w = '{act: ACT_NONE, cond: C_ALWAYS, wait_slot: 1'b0,
                     on_true: S_IDLE, on_false: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/pul_rank_if.sv]
// ----------------------------------------------------------------------------
// pul_rank_if
// Input channel: one rank per word.
// ----------------------------------------------------------------------------
interface pul_rank_if;
  logic           valid;
  logic           ready;
  pul_pkg::rank_t rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

[hw/rtl/pul_elem_if.sv]
// ----------------------------------------------------------------------------
// pul_elem_if
// Result channel: one permutation element per word.
// ----------------------------------------------------------------------------
interface pul_elem_if;
  logic           valid;
  logic           ready;
  pul_pkg::pos_t  position;
  pul_pkg::elem_t element;
  logic           last;
  logic           rank_error;

  modport source (output valid, output position, output element, output last,
                  output rank_error, input ready);
  modport sink   (input valid, input position, input element, input last,
                  input rank_error, output ready);
endinterface

[hw/rtl/permutation_unrank_lehmer.sv]
// ----------------------------------------------------------------------------
// permutation_unrank_lehmer
// Ranks of n! or more give a single error word in place of a permutation.
// One rank is in work at a time: the input is not ready again until the last
// word of the rank is registered, and words wait while the output register
// is full. A single subtract-and-compare unit peels off factorials one per
// cycle. Reset is synchronous and active low; it idles the sequencer, empties
// the output register and sets n to 12.
// ----------------------------------------------------------------------------
module permutation_unrank_lehmer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  pul_pkg::size_t     cfg_wdata,
  pul_rank_if.sink           in_rank,
  pul_elem_if.source         out_elem
);

  pul_pkg::step_t      pc_r, pc_nxt;
  pul_pkg::size_t      size_r;
  pul_pkg::rank_t      r_r, r_nxt;
  pul_pkg::size_t      k_r, k_nxt;
  pul_pkg::elem_t      p_r, p_nxt;
  pul_pkg::vmask_t     used_r, used_nxt;
  logic                out_valid_r, out_valid_nxt;
  pul_pkg::pos_t       out_pos_r, out_pos_nxt;
  pul_pkg::elem_t      out_elem_r, out_elem_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_err_r, out_err_nxt;

  pul_pkg::ctrl_word_t cw;
  logic                slot_free;
  logic                stall;
  logic                in_fire;
  logic                is_last;
  logic                r_ge;
  logic                cond_true;
  pul_pkg::size_t      fidx;
  pul_pkg::rank_t      f_val;
  pul_pkg::vmask_t     valid_mask;
  pul_pkg::vmask_t     free_vec;
  pul_pkg::vmask_t     used_emit;

  function automatic pul_pkg::elem_t next_free(input pul_pkg::vmask_t free,
                                               input pul_pkg::elem_t after);
    pul_pkg::elem_t res;
    res = '0;
    for (int v = pul_pkg::MAX_SIZE; v >= 1; v--) begin
      if (free[v] && (pul_pkg::elem_t'(v) > after)) begin
        res = pul_pkg::elem_t'(v);
      end
    end
    return res;
  endfunction

  assign cw        = pul_pkg::ucode(pc_r);
  assign slot_free = !out_valid_r || out_elem.ready;
  assign stall     = cw.wait_slot && !slot_free;
  assign in_rank.ready = (cw.act == pul_pkg::ACT_LOAD);
  assign in_fire   = in_rank.valid && in_rank.ready;
  assign is_last   = (k_r == size_r - 4'd1);
  assign fidx      = (pc_r == pul_pkg::S_CHECK) ? size_r : (size_r - 4'd1 - k_r);
  assign f_val     = pul_pkg::fact(fidx);
  assign r_ge      = (r_r >= f_val);

  always_comb begin
    for (int v = 0; v <= pul_pkg::MAX_SIZE; v++) begin
      valid_mask[v] = (v >= 1) && (pul_pkg::size_t'(v) <= size_r);
    end
  end

  assign free_vec  = ~used_r & valid_mask;
  assign used_emit = used_r | (pul_pkg::vmask_t'(1) << p_r);

  always_comb begin
    case (cw.cond)
      pul_pkg::C_ALWAYS: cond_true = 1'b1;
      pul_pkg::C_ACCEPT: cond_true = in_fire;
      pul_pkg::C_GE:     cond_true = r_ge;
      pul_pkg::C_LAST:   cond_true = is_last;
      default:           cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (cond_true) begin
      pc_nxt = cw.on_true;
    end else begin
      pc_nxt = cw.on_false;
    end
  end

  always_comb begin
    r_nxt         = r_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && !out_elem.ready;
    out_pos_nxt   = out_pos_r;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    case (cw.act)
      pul_pkg::ACT_LOAD: begin
        if (in_fire) begin
          r_nxt    = in_rank.rank;
          k_nxt    = '0;
          p_nxt    = pul_pkg::elem_t'(1);
          used_nxt = '0;
        end
      end
      pul_pkg::ACT_SUB: begin
        if (r_ge) begin
          r_nxt = r_r - f_val;
          p_nxt = next_free(free_vec, p_r);
        end
      end
      pul_pkg::ACT_EMIT: begin
        if (!stall) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = k_r;
          out_elem_nxt  = p_r;
          out_last_nxt  = is_last;
          out_err_nxt   = 1'b0;
          used_nxt      = used_emit;
          k_nxt         = k_r + 4'd1;
          p_nxt         = next_free(~used_emit & valid_mask, '0);
        end
      end
      pul_pkg::ACT_ERR: begin
        if (!stall) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = '0;
          out_elem_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= pul_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      size_r      <= pul_pkg::size_t'(pul_pkg::MAX_SIZE);
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_wdata == '0) begin
          size_r <= pul_pkg::size_t'(1);
        end else if (cfg_wdata > pul_pkg::size_t'(pul_pkg::MAX_SIZE)) begin
          size_r <= pul_pkg::size_t'(pul_pkg::MAX_SIZE);
        end else begin
          size_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    k_r        <= k_nxt;
    p_r        <= p_nxt;
    used_r     <= used_nxt;
    out_pos_r  <= out_pos_nxt;
    out_elem_r <= out_elem_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_elem.valid      = out_valid_r;
  assign out_elem.position   = out_pos_r;
  assign out_elem.element    = out_elem_r;
  assign out_elem.last       = out_last_r;
  assign out_elem.rank_error = out_err_r;

  a_fire_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (pc_r == pul_pkg::S_CHECK))
    else $error("accepted rank did not enter the range check");

  a_pick_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == pul_pkg::S_EMIT) |-> free_vec[p_r])
    else $error("selected element is already used or out of range");

  a_digit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == pul_pkg::S_SUB) |-> (k_r < size_r))
    else $error("digit index ran past the permutation size");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_last_r && (out_elem_r == '0)))
    else $error("error word is not a single terminal word");

endmodule

[dv/tb_permutation_unrank_lehmer.sv]
// ----------------------------------------------------------------------------
// tb_permutation_unrank_lehmer
// Drives ranks into the unranking block and checks every element word that
// comes back against a permutation computed in the testbench. A directed pass
// covers the size extremes, size clamping and out-of-range ranks. Random
// passes follow under several sizes, first with both sides idling, then with
// neither idling, including one long receiver stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_permutation_unrank_lehmer;

  typedef struct packed {
    pul_pkg::pos_t  position;
    pul_pkg::elem_t element;
    logic           last;
    logic           rank_error;
  } elem_word_t;

  logic           clk;
  logic           rst_n;
  logic           cfg_we;
  pul_pkg::size_t cfg_wdata;

  pul_rank_if rank_ch ();
  pul_elem_if elem_ch ();

  permutation_unrank_lehmer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_rank   (rank_ch),
    .out_elem  (elem_ch)
  );

  pul_pkg::rank_t ranks_to_send[$];
  elem_word_t     expected_elems[$];
  pul_pkg::size_t size_reg;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             failures = 0;
  int             hold_left;
  int             hold_seq;
  int             hold_seen;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic longint factorial(input int m);
    longint p;
    p = 1;
    for (int i = 2; i <= m; i++) p = p * i;
    return p;
  endfunction

  function automatic int effective_n(input pul_pkg::size_t s);
    int n;
    n = s;
    if (n < 1) n = 1;
    if (n > pul_pkg::MAX_SIZE) n = pul_pkg::MAX_SIZE;
    return n;
  endfunction

  // Lexicographic unranking through the factorial number system.
  function automatic void predict_permutation(input pul_pkg::rank_t r);
    int              n;
    longint          rem;
    longint          f;
    longint          digit;
    pul_pkg::vmask_t taken;
    int              seen;
    int              pick;
    elem_word_t      w;
    n = effective_n(size_reg);
    rem = r;
    if (rem >= factorial(n)) begin
      w = '{position: '0, element: '0, last: 1'b1, rank_error: 1'b1};
      expected_elems.push_back(w);
      return;
    end
    taken = '0;
    for (int k = 0; k < n; k++) begin
      f = factorial(n - 1 - k);
      digit = rem / f;
      rem = rem % f;
      seen = 0;
      pick = 0;
      for (int v = 1; v <= n; v++) begin
        if (!taken[v] && pick == 0) begin
          if (seen == digit) pick = v;
          else seen++;
        end
      end
      if (pick != 0) taken[pick] = 1'b1;
      w.position   = pul_pkg::pos_t'(k);
      w.element    = pul_pkg::elem_t'(pick);
      w.last       = (k == n - 1);
      w.rank_error = 1'b0;
      expected_elems.push_back(w);
    end
  endfunction

  function automatic pul_pkg::rank_t random_rank(input int n);
    int          roll;
    int unsigned lim;
    roll = $urandom_range(0, 99);
    lim = int'(factorial(n));
    if (roll < 84) return pul_pkg::rank_t'($urandom_range(0, lim - 1));
    if (roll < 92) return pul_pkg::rank_t'($urandom());
    return pul_pkg::rank_t'(lim + $urandom_range(0, 3));
  endfunction

  // Rank driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      rank_ch.valid <= 1'b0;
      rank_ch.rank  <= '0;
    end else begin
      if (rank_ch.valid && rank_ch.ready) predict_permutation(rank_ch.rank);
      if (!rank_ch.valid || rank_ch.ready) begin
        if (ranks_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          rank_ch.valid <= 1'b1;
          rank_ch.rank  <= ranks_to_send.pop_front();
        end else begin
          rank_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_seq) begin
      hold_left <= 400;
      hold_seen <= hold_seq;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Element monitor and checker.
  always @(posedge clk) begin : elem_monitor
    elem_word_t want;
    if (!rst_n) begin
      elem_ch.ready <= 1'b0;
    end else begin
      if (elem_ch.valid && elem_ch.ready) begin
        if (expected_elems.size() == 0) begin
          $error("unexpected word: position %0d element %0d last %0d rank_error %0d",
                 elem_ch.position, elem_ch.element, elem_ch.last, elem_ch.rank_error);
          failures++;
        end else begin
          want = expected_elems.pop_front();
          if (elem_ch.position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, elem_ch.position);
            failures++;
          end
          if (elem_ch.element !== want.element) begin
            $error("element: expected %0d, actual %0d", want.element, elem_ch.element);
            failures++;
          end
          if (elem_ch.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, elem_ch.last);
            failures++;
          end
          if (elem_ch.rank_error !== want.rank_error) begin
            $error("rank_error: expected %0d, actual %0d", want.rank_error,
                   elem_ch.rank_error);
            failures++;
          end
        end
      end
      elem_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  task automatic write_size(input pul_pkg::size_t v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_reg  = v;
  endtask

  task automatic drain();
    while (!(ranks_to_send.size() == 0 && !rank_ch.valid && expected_elems.size() == 0))
      @(negedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_batch(input pul_pkg::rank_t list[$]);
    foreach (list[i]) ranks_to_send.push_back(list[i]);
    drain();
  endtask

  initial begin : stimulus
    pul_pkg::size_t size_plan[9];
    size_plan = '{4'd12, 4'd4, 4'd0, 4'd15, 4'd1, 4'd8, 4'd12, 4'd13, 4'd6};
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    size_reg      = 4'd12;
    hold_seq      = 0;
    send_idle_pct = 34;
    recv_idle_pct = 61;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_batch('{29'd0, 29'd479001599, 29'd479001600, 29'h1FFFFFFF, 29'd1, 29'd39916800});
    write_size(4'd1);
    send_batch('{29'd0, 29'd1});
    write_size(4'd0);
    send_batch('{29'd0, 29'd1});
    write_size(4'd15);
    send_batch('{29'd479001599, 29'd479001600});
    write_size(4'd13);
    send_batch('{29'd123456789});
    write_size(4'd2);
    send_batch('{29'd0, 29'd1, 29'd2});
    write_size(4'd3);
    send_batch('{29'd3, 29'd5, 29'd6});

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = (m == 0) ? 34 : (m == 1) ? 61 : 0;
      recv_idle_pct = (m == 0) ? 61 : (m == 1) ? 34 : 0;
      for (int s = 0; s < 3; s++) begin
        write_size(size_plan[m * 3 + s]);
        if (m == 2 && s == 0) hold_seq <= hold_seq + 1;
        for (int i = 0; i < 18; i++)
          ranks_to_send.push_back(random_rank(effective_n(size_reg)));
        drain();
      end
    end

    if (failures == 0 && expected_elems.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
